### sv/tklb_pkg.sv
// shared types and constants of the top-k leaderboard table
// no dependencies
package tklb_pkg;

    localparam int KEY_W       = 32;
    localparam int SCORE_W     = 32;
    localparam int CMD_W       = 2;
    localparam int RANGE_W     = 8;
    localparam int RANK_W      = 6;
    localparam int LIMIT_W     = 6;
    localparam int MAX_RESULTS = 32;
    localparam int REM_W       = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W     = KEY_W + SCORE_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_REPORT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_RANGE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } t_entry;

endpackage

### sv/tklb_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tklb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/top_k_leaderboard_table.sv
// top-k leaderboard table: sorted (key, score) table with report, query, range and clear
// depends on tklb_pkg and tklb_ram
//
// usage
//   input channel (i_in_valid / o_in_ready) takes one command per transfer:
//   report score, rank query, range read or clear. the output channel
//   (o_out_valid / i_out_ready) returns one result per transfer; report,
//   query, clear and an empty range give one result, a range read gives one
//   result per entry with o_last_item on the final one.
//   i_cfg_we writes the entry limit at any edge; write it only while idle.
// steps
//   report: a scan over the entry ram and a decision; if the entry is kept,
//   a shift of |old - new position| entries and a write of the entry; then
//   a load into the output register. query: a scan, a decision and the
//   output register. clear: straight to the output register. range read:
//   each entry is read from the entry ram and loaded before the next is read.
//   one command is worked on at a time; o_in_ready is high only when idle.
// reset
//   synchronous, active low: the table is emptied (fill count cleared) and
//   the entry limit goes to 32; ram contents are left alone and never read.
// backpressure
//   a result waits in the output register while i_out_ready is low; a new
//   command is still taken meanwhile and stalls only when its own result is due.
module top_k_leaderboard_table #(
    parameter int CAPACITY = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [tklb_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    // command channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tklb_pkg::CMD_W-1:0]     i_command,
    input  logic [tklb_pkg::KEY_W-1:0]     i_player_key,
    input  logic [tklb_pkg::SCORE_W-1:0]   i_score,
    input  logic [tklb_pkg::RANGE_W-1:0]   i_range_start,
    input  logic [tklb_pkg::RANGE_W-1:0]   i_range_count,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tklb_pkg::RANK_W-1:0]    o_rank_found,
    output logic [tklb_pkg::KEY_W-1:0]     o_entry_key,
    output logic [tklb_pkg::SCORE_W-1:0]   o_entry_score,
    output logic                           o_entry_valid,
    output logic [tklb_pkg::RANK_W-1:0]    o_entry_count,
    output logic                           o_last_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_RESP,
        S_RNG_RD,
        S_RNG_WT
    } t_state;

    t_state                         r_state;
    logic [tklb_pkg::LIMIT_W-1:0]   r_limit;
    logic [CW-1:0]                  r_filled;
    tklb_pkg::t_cmd                 r_cmd;
    logic [tklb_pkg::KEY_W-1:0]     r_key;
    logic [tklb_pkg::SCORE_W-1:0]   r_score;

    // scan
    logic [CW-1:0]                  r_idx;
    logic                           r_rvld;
    logic [AW-1:0]                  r_chk;
    logic                           r_found;
    logic [AW-1:0]                  r_pos;
    logic [CW-1:0]                  r_ge;
    logic [CW-1:0]                  r_gt;
    logic [tklb_pkg::SCORE_W-1:0]   r_last_sc;

    // shift and place
    logic                           r_up;
    logic [AW-1:0]                  r_src;
    logic [AW-1:0]                  r_dst;
    logic [CW-1:0]                  r_nleft;
    logic [AW-1:0]                  r_q;
    logic                           r_append;
    logic [CW-1:0]                  r_rank;

    // range read
    logic [tklb_pkg::REM_W-1:0]     r_rem;

    // output register
    logic                           r_out_valid;
    logic [tklb_pkg::RANK_W-1:0]    r_o_rank;
    logic [tklb_pkg::KEY_W-1:0]     r_o_key;
    logic [tklb_pkg::SCORE_W-1:0]   r_o_score;
    logic                           r_o_evld;
    logic [tklb_pkg::RANK_W-1:0]    r_o_count;
    logic                           r_o_last;

    // ram port
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [tklb_pkg::ENTRY_W-1:0]   ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [tklb_pkg::ENTRY_W-1:0]   ram_rdata;
    tklb_pkg::t_entry               rd_ent;

    logic                           out_free;
    logic                           out_load;
    logic                           scan_more;

    // placement decision
    logic [6:0]                     lim7;
    logic                           room;
    logic                           beats_last;
    logic                           keep;
    logic [CW-1:0]                  p_c;
    logic [CW-1:0]                  q_c;
    logic                           up_c;
    logic [CW-1:0]                  nmov_c;
    logic [CW-1:0]                  src_c;

    // range setup
    logic [8:0]                     start9;
    logic [8:0]                     fill9;
    logic [8:0]                     avail9;
    logic [8:0]                     cnt9;
    logic [8:0]                     n9;
    logic                           rng_empty;

    tklb_ram #(
        .WIDTH (tklb_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent    = tklb_pkg::t_entry'(ram_rdata);
    assign out_free  = !r_out_valid || i_out_ready;
    // output register takes a new result this cycle
    assign out_load  = out_free && ((r_state == S_RESP) || (r_state == S_RNG_WT));
    assign scan_more = (r_idx < r_filled);

    // ram access per state: reads for scan, shift and range; writes for shift and place
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_src;
        ram_we    = 1'b0;
        ram_waddr = r_dst;
        ram_wdata = ram_rdata;
        unique case (r_state)
            S_SCAN: begin
                ram_re    = scan_more;
                ram_raddr = r_idx[AW-1:0];
            end
            S_SHIFT: begin
                ram_re    = (r_nleft != '0);
                ram_raddr = r_src;
                ram_we    = r_rvld;
                ram_waddr = r_dst;
                ram_wdata = ram_rdata;
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_q;
                ram_wdata = {r_key, r_score};
            end
            S_RNG_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_pos;
            end
            default: begin
            end
        endcase
    end

    // where the reported entry comes from (p) and where it lands (q)
    always_comb begin
        if (r_limit == '0) begin
            lim7 = 7'd1;
        end else if ({1'b0, r_limit} > 7'(CAPACITY)) begin
            lim7 = 7'(CAPACITY);
        end else begin
            lim7 = {1'b0, r_limit};
        end
        room       = 8'(r_filled) < 8'(lim7);
        beats_last = (r_filled != '0) && (r_score > r_last_sc);
        keep       = r_found || room || beats_last;
        if (r_found) begin
            // new rank counts higher-or-equal entries before it, strictly higher after it
            p_c = CW'(r_pos);
            q_c = r_ge + r_gt;
        end else if (room) begin
            p_c = r_filled;
            q_c = r_ge;
        end else begin
            // last entry is replaced only when strictly beaten, so r_ge excludes it
            p_c = r_filled - 1'b1;
            q_c = r_ge;
        end
        up_c   = (q_c < p_c);
        nmov_c = up_c ? (p_c - q_c) : (q_c - p_c);
        src_c  = up_c ? (p_c - 1'b1) : (p_c + 1'b1);
    end

    // range length clipped to the fill and to the result limit
    always_comb begin
        start9    = {1'b0, i_range_start};
        fill9     = 9'(r_filled);
        avail9    = fill9 - start9;
        rng_empty = (start9 >= fill9) || (i_range_count == '0);
        cnt9      = (9'(i_range_count) < avail9) ? 9'(i_range_count) : avail9;
        n9        = (cnt9 > 9'(tklb_pkg::MAX_RESULTS)) ? 9'(tklb_pkg::MAX_RESULTS) : cnt9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= tklb_pkg::LIMIT_RESET;
            r_filled    <= '0;
            r_rvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= tklb_pkg::t_cmd'(i_command);
                        r_key   <= i_player_key;
                        r_score <= i_score;
                        unique case (tklb_pkg::t_cmd'(i_command))
                            tklb_pkg::CMD_REPORT, tklb_pkg::CMD_QUERY: begin
                                r_idx   <= '0;
                                r_rvld  <= 1'b0;
                                r_found <= 1'b0;
                                r_ge    <= '0;
                                r_gt    <= '0;
                                r_state <= S_SCAN;
                            end
                            tklb_pkg::CMD_RANGE: begin
                                if (rng_empty) begin
                                    r_rank  <= '0;
                                    r_state <= S_RESP;
                                end else begin
                                    r_pos   <= AW'(i_range_start);
                                    r_rem   <= tklb_pkg::REM_W'(n9);
                                    r_state <= S_RNG_RD;
                                end
                            end
                            tklb_pkg::CMD_CLEAR: begin
                                r_filled <= '0;
                                r_rank   <= '0;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (scan_more) begin
                        r_idx  <= r_idx + 1'b1;
                        r_rvld <= 1'b1;
                        r_chk  <= r_idx[AW-1:0];
                    end else begin
                        r_rvld <= 1'b0;
                    end
                    if (r_rvld) begin
                        r_last_sc <= rd_ent.score;
                        if (!r_found && (rd_ent.key == r_key)) begin
                            r_found <= 1'b1;
                            r_pos   <= r_chk;
                        end else if (!r_found) begin
                            if (rd_ent.score >= r_score) begin
                                r_ge <= r_ge + 1'b1;
                            end
                        end else if (rd_ent.score > r_score) begin
                            r_gt <= r_gt + 1'b1;
                        end
                    end
                    if (!scan_more && !r_rvld) begin
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    if (r_cmd == tklb_pkg::CMD_QUERY) begin
                        r_rank  <= r_found ? (CW'(r_pos) + 1'b1) : '0;
                        r_state <= S_RESP;
                    end else if (keep) begin
                        r_up     <= up_c;
                        r_nleft  <= nmov_c;
                        r_src    <= AW'(src_c);
                        r_q      <= AW'(q_c);
                        r_append <= !r_found && room;
                        r_rvld   <= 1'b0;
                        r_state  <= S_SHIFT;
                    end else begin
                        r_rank  <= '0;
                        r_state <= S_RESP;
                    end
                end

                S_SHIFT: begin
                    // read one entry a cycle, write it one slot over on the next
                    if (r_nleft != '0) begin
                        r_rvld  <= 1'b1;
                        r_dst   <= r_up ? (r_src + 1'b1) : (r_src - 1'b1);
                        r_src   <= r_up ? (r_src - 1'b1) : (r_src + 1'b1);
                        r_nleft <= r_nleft - 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                        if (!r_rvld) begin
                            r_state <= S_PLACE;
                        end
                    end
                end

                S_PLACE: begin
                    if (r_append) begin
                        r_filled <= r_filled + 1'b1;
                    end
                    r_rank  <= CW'(r_q) + 1'b1;
                    r_state <= S_RESP;
                end

                S_RESP: begin
                    if (out_free) begin
                        r_o_rank    <= tklb_pkg::RANK_W'(r_rank);
                        r_o_key     <= '0;
                        r_o_score   <= '0;
                        r_o_evld    <= 1'b0;
                        r_o_count   <= tklb_pkg::RANK_W'(r_filled);
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                S_RNG_RD: begin
                    r_state <= S_RNG_WT;
                end

                S_RNG_WT: begin
                    if (out_free) begin
                        r_o_rank    <= tklb_pkg::RANK_W'(32'(r_pos) + 32'd1);
                        r_o_key     <= rd_ent.key;
                        r_o_score   <= rd_ent.score;
                        r_o_evld    <= 1'b1;
                        r_o_count   <= tklb_pkg::RANK_W'(r_filled);
                        r_o_last    <= (r_rem == tklb_pkg::REM_W'(1));
                        if (r_rem == tklb_pkg::REM_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_rem   <= r_rem - 1'b1;
                            r_state <= S_RNG_RD;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_rank_found  = r_o_rank;
    assign o_entry_key   = r_o_key;
    assign o_entry_score = r_o_score;
    assign o_entry_valid = r_o_evld;
    assign o_entry_count = r_o_count;
    assign o_last_item   = r_o_last;

endmodule

### sv/tklb_checker.sv
// port-level checks of the top-k leaderboard table, bound to the top level
// depends on tklb_pkg and top_k_leaderboard_table
module tklb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [tklb_pkg::RANK_W-1:0]  o_rank_found,
    input logic [tklb_pkg::KEY_W-1:0]   o_entry_key,
    input logic [tklb_pkg::SCORE_W-1:0] o_entry_score,
    input logic                         o_entry_valid,
    input logic [tklb_pkg::RANK_W-1:0]  o_entry_count,
    input logic                         o_last_item
);

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rank_found)
            && $stable(o_entry_key) && $stable(o_entry_score)
            && $stable(o_entry_valid) && $stable(o_entry_count) && $stable(o_last_item))
        else $error("result changed while stalled");

    // a result without an entry is always the only result of its command
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> o_last_item)
        else $error("entry-less result not marked last");

    // entry fields are zero unless an entry is carried
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> (o_entry_key == '0) && (o_entry_score == '0))
        else $error("entry fields not zero");

    // one command at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command taken while previous one in flight");

endmodule

bind top_k_leaderboard_table tklb_checker u_tklb_checker (.*);
